### hw/rtl/tpo_pkg.sv
// Shared constants and helpers for the triangle pair overlap unit.
`timescale 1ns / 1ps
package tpo_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int TOL_BITS       = 20;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 20'd1;
   localparam int NUM_COORDS     = 12;
   localparam int NUM_SIDES      = 2;
   localparam int NUM_VERTS      = 3;
   localparam int RSP_BITS       = 8;

   function automatic int next_vert(input int v);
      return (v == NUM_VERTS - 1) ? 0 : v + 1;
   endfunction

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

### hw/rtl/tpo_diff.sv
// Stage 1: edge vectors, vertex offsets and widened segment box tests.
`timescale 1ns / 1ps
module tpo_diff #(
   parameter int CB = tpo_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [CB-1:0]          pt_x [0:1][0:2],
   input  logic signed [CB-1:0]          pt_y [0:1][0:2],
   input  logic [tpo_pkg::TOL_BITS-1:0]  tolerance,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [CB:0]            ux [0:1][0:2],
   output logic signed [CB:0]            uy [0:1][0:2],
   output logic signed [CB:0]            vx [0:1][0:2][0:2],
   output logic signed [CB:0]            vy [0:1][0:2][0:2],
   output logic                          in_box [0:1][0:2][0:2]
);
   import tpo_pkg::*;

   localparam int BOX_BITS = max_int(CB, TOL_BITS + 1) + 2;

   logic                valid_ff;
   logic signed [CB:0]  ux_ff [0:1][0:2];
   logic signed [CB:0]  ux_in [0:1][0:2];
   logic signed [CB:0]  uy_ff [0:1][0:2];
   logic signed [CB:0]  uy_in [0:1][0:2];
   logic signed [CB:0]  vx_ff [0:1][0:2][0:2];
   logic signed [CB:0]  vx_in [0:1][0:2][0:2];
   logic signed [CB:0]  vy_ff [0:1][0:2][0:2];
   logic signed [CB:0]  vy_in [0:1][0:2][0:2];
   logic                box_ff [0:1][0:2][0:2];
   logic                box_in [0:1][0:2][0:2];
   logic                advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;

   always_comb begin
      int nv;
      int os;
      logic signed [BOX_BITS-1:0] eps;
      logic signed [BOX_BITS-1:0] x0, x1, y0, y1, px, py;
      logic signed [BOX_BITS-1:0] lo_x, hi_x, lo_y, hi_y;
      eps = BOX_BITS'(tolerance);
      for (int s = 0; s < NUM_SIDES; s++) begin
         os = NUM_SIDES - 1 - s;
         for (int e = 0; e < NUM_VERTS; e++) begin
            nv = next_vert(e);
            ux_in[s][e] = (CB+1)'(pt_x[s][nv]) - (CB+1)'(pt_x[s][e]);
            uy_in[s][e] = (CB+1)'(pt_y[s][nv]) - (CB+1)'(pt_y[s][e]);
            x0 = BOX_BITS'(pt_x[s][e]);
            x1 = BOX_BITS'(pt_x[s][nv]);
            y0 = BOX_BITS'(pt_y[s][e]);
            y1 = BOX_BITS'(pt_y[s][nv]);
            lo_x = ((x0 < x1) ? x0 : x1) - eps;
            hi_x = ((x0 > x1) ? x0 : x1) + eps;
            lo_y = ((y0 < y1) ? y0 : y1) - eps;
            hi_y = ((y0 > y1) ? y0 : y1) + eps;
            for (int k = 0; k < NUM_VERTS; k++) begin
               vx_in[s][e][k] = (CB+1)'(pt_x[os][k]) - (CB+1)'(pt_x[s][e]);
               vy_in[s][e][k] = (CB+1)'(pt_y[os][k]) - (CB+1)'(pt_y[s][e]);
               px = BOX_BITS'(pt_x[os][k]);
               py = BOX_BITS'(pt_y[os][k]);
               box_in[s][e][k] = (px >= lo_x) && (px <= hi_x) &&
                                 (py >= lo_y) && (py <= hi_y);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ux_ff  <= ux_in;
         uy_ff  <= uy_in;
         vx_ff  <= vx_in;
         vy_ff  <= vy_in;
         box_ff <= box_in;
      end
   end

   assign out_valid = valid_ff;
   assign ux        = ux_ff;
   assign uy        = uy_ff;
   assign vx        = vx_ff;
   assign vy        = vy_ff;
   assign in_box    = box_ff;

endmodule

### hw/rtl/tpo_orient.sv
// Stages 2 and 3: cross products, then orientation values.
`timescale 1ns / 1ps
module tpo_orient #(
   parameter int CB = tpo_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [CB:0]    ux [0:1][0:2],
   input  logic signed [CB:0]    uy [0:1][0:2],
   input  logic signed [CB:0]    vx [0:1][0:2][0:2],
   input  logic signed [CB:0]    vy [0:1][0:2][0:2],
   input  logic                  in_box [0:1][0:2][0:2],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [2*CB+2:0] orient [0:1][0:2][0:2],
   output logic                  out_box [0:1][0:2][0:2]
);
   import tpo_pkg::*;

   localparam int PW = 2 * (CB + 1);
   localparam int OW = 2 * CB + 3;

   logic                 valid2_ff;
   logic                 valid3_ff;
   logic                 advance2;
   logic                 advance3;
   logic signed [PW-1:0] p1_ff [0:1][0:2][0:2];
   logic signed [PW-1:0] p1_in [0:1][0:2][0:2];
   logic signed [PW-1:0] p2_ff [0:1][0:2][0:2];
   logic signed [PW-1:0] p2_in [0:1][0:2][0:2];
   logic                 box2_ff [0:1][0:2][0:2];
   logic signed [OW-1:0] ori_ff [0:1][0:2][0:2];
   logic signed [OW-1:0] ori_in [0:1][0:2][0:2];
   logic                 box3_ff [0:1][0:2][0:2];

   assign advance3 = !valid3_ff || out_ready;
   assign advance2 = !valid2_ff || advance3;
   assign in_ready = advance2;

   always_comb begin
      for (int s = 0; s < NUM_SIDES; s++) begin
         for (int e = 0; e < NUM_VERTS; e++) begin
            for (int k = 0; k < NUM_VERTS; k++) begin
               p1_in[s][e][k]  = PW'(ux[s][e]) * PW'(vy[s][e][k]);
               p2_in[s][e][k]  = PW'(uy[s][e]) * PW'(vx[s][e][k]);
               ori_in[s][e][k] = OW'(p1_ff[s][e][k]) - OW'(p2_ff[s][e][k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (advance2) begin
            valid2_ff <= in_valid;
         end
         if (advance3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance2) begin
         p1_ff   <= p1_in;
         p2_ff   <= p2_in;
         box2_ff <= in_box;
      end
      if (advance3) begin
         ori_ff  <= ori_in;
         box3_ff <= box2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign orient    = ori_ff;
   assign out_box   = box3_ff;

endmodule

### hw/rtl/tpo_decide.sv
// Stages 4 and 5: sign and tolerance flags, then edge and containment verdict.
`timescale 1ns / 1ps
module tpo_decide #(
   parameter int CB = tpo_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [2*CB+2:0]        orient [0:1][0:2][0:2],
   input  logic                          in_box [0:1][0:2][0:2],
   input  logic [tpo_pkg::TOL_BITS-1:0]  tolerance,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          overlap
);
   import tpo_pkg::*;

   localparam int OW = 2 * CB + 3;
   localparam int CW = max_int(OW, TOL_BITS + 1) + 1;

   typedef struct packed {
      logic pos;
      logic neg;
      logic above;
      logic below;
   } ori_flags_type;

   logic          valid4_ff;
   logic          valid5_ff;
   logic          advance4;
   logic          advance5;
   ori_flags_type flg_ff [0:1][0:2][0:2];
   ori_flags_type flg_in [0:1][0:2][0:2];
   logic          box4_ff [0:1][0:2][0:2];
   logic          hit_ff;
   logic          hit_in;

   assign advance5 = !valid5_ff || out_ready;
   assign advance4 = !valid4_ff || advance5;
   assign in_ready = advance4;

   always_comb begin
      logic signed [CW-1:0] eps;
      logic signed [CW-1:0] o;
      eps = CW'(tolerance);
      for (int s = 0; s < NUM_SIDES; s++) begin
         for (int e = 0; e < NUM_VERTS; e++) begin
            for (int k = 0; k < NUM_VERTS; k++) begin
               o = CW'(orient[s][e][k]);
               flg_in[s][e][k].pos   = o > 0;
               flg_in[s][e][k].neg   = o < 0;
               flg_in[s][e][k].above = o > eps;
               flg_in[s][e][k].below = o < -eps;
            end
         end
      end
   end

   always_comb begin
      int ni;
      int nj;
      logic cross_a;
      logic cross_b;
      logic any_pos;
      logic any_neg;
      hit_in = 1'b0;
      for (int i = 0; i < NUM_VERTS; i++) begin
         ni = next_vert(i);
         for (int j = 0; j < NUM_VERTS; j++) begin
            nj = next_vert(j);
            cross_a = (flg_ff[0][i][j].pos && flg_ff[0][i][nj].neg) ||
                      (flg_ff[0][i][j].neg && flg_ff[0][i][nj].pos);
            cross_b = (flg_ff[1][j][i].pos && flg_ff[1][j][ni].neg) ||
                      (flg_ff[1][j][i].neg && flg_ff[1][j][ni].pos);
            hit_in = hit_in || (cross_a && cross_b);
         end
      end
      for (int s = 0; s < NUM_SIDES; s++) begin
         for (int e = 0; e < NUM_VERTS; e++) begin
            for (int k = 0; k < NUM_VERTS; k++) begin
               hit_in = hit_in || (!flg_ff[s][e][k].above && !flg_ff[s][e][k].below &&
                                   box4_ff[s][e][k]);
            end
         end
      end
      for (int s = 0; s < NUM_SIDES; s++) begin
         for (int k = 0; k < NUM_VERTS; k++) begin
            any_pos = 1'b0;
            any_neg = 1'b0;
            for (int e = 0; e < NUM_VERTS; e++) begin
               any_pos = any_pos || flg_ff[s][e][k].above;
               any_neg = any_neg || flg_ff[s][e][k].below;
            end
            hit_in = hit_in || !(any_pos && any_neg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (advance4) begin
            valid4_ff <= in_valid;
         end
         if (advance5) begin
            valid5_ff <= valid4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance4) begin
         flg_ff  <= flg_in;
         box4_ff <= in_box;
      end
      if (advance5) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid5_ff;
   assign overlap   = hit_ff;

endmodule

### hw/rtl/triangle_pair_overlap_2d_unit.sv
// Top level of the triangle pair overlap unit: stream ports and tolerance register.
//
//  port group | dir | contents
//  req_*      | in  | one triangle pair per request
//  rsp_*      | out | overlap verdict, one per request
//  csr_*      | in  | tolerance register write
//
// One request per cycle while responses are accepted; requests pass through the difference,
// product, orientation, flag and verdict stages.
// Every stage holds its own valid bit, so a stalled response blocks only
// the stages behind it and bubbles close up.
// Reset empties the pipeline and sets the tolerance to one.
`timescale 1ns / 1ps
module triangle_pair_overlap_2d_unit #(
   parameter int COORD_BITS = tpo_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tri_a_v0_x, tri_a_v0_y, tri_a_v1_x, tri_a_v1_y, tri_a_v2_x, tri_a_v2_y,
   // tri_b_v0_x, tri_b_v0_y, tri_b_v1_x, tri_b_v1_y, tri_b_v2_x, tri_b_v2_y
   input  logic [((tpo_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // overlap
   output logic [tpo_pkg::RSP_BITS-1:0]          rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [tpo_pkg::TOL_BITS-1:0]          csr_wr_data
);
   import tpo_pkg::*;

   logic [TOL_BITS-1:0]       tolerance_ff;
   logic signed [COORD_BITS-1:0] pt_x [0:1][0:2];
   logic signed [COORD_BITS-1:0] pt_y [0:1][0:2];

   logic                      s1_valid;
   logic                      s1_ready;
   logic signed [COORD_BITS:0] ux [0:1][0:2];
   logic signed [COORD_BITS:0] uy [0:1][0:2];
   logic signed [COORD_BITS:0] vx [0:1][0:2][0:2];
   logic signed [COORD_BITS:0] vy [0:1][0:2][0:2];
   logic                      box1 [0:1][0:2][0:2];

   logic                      s3_valid;
   logic                      s3_ready;
   logic signed [2*COORD_BITS+2:0] orient [0:1][0:2][0:2];
   logic                      box3 [0:1][0:2][0:2];

   logic                      overlap;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tolerance_ff <= csr_wr_data;
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_SIDES; s++) begin
         for (int v = 0; v < NUM_VERTS; v++) begin
            pt_x[s][v] = req_tdata[(s*6 + v*2)*COORD_BITS +: COORD_BITS];
            pt_y[s][v] = req_tdata[(s*6 + v*2 + 1)*COORD_BITS +: COORD_BITS];
         end
      end
   end

   tpo_diff #(.CB(COORD_BITS)) u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .pt_x      (pt_x),
      .pt_y      (pt_y),
      .tolerance (tolerance_ff),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .ux        (ux),
      .uy        (uy),
      .vx        (vx),
      .vy        (vy),
      .in_box    (box1)
   );

   tpo_orient #(.CB(COORD_BITS)) u_orient (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .ux        (ux),
      .uy        (uy),
      .vx        (vx),
      .vy        (vy),
      .in_box    (box1),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .orient    (orient),
      .out_box   (box3)
   );

   tpo_decide #(.CB(COORD_BITS)) u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .orient    (orient),
      .in_box    (box3),
      .tolerance (tolerance_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .overlap   (overlap)
   );

   assign rsp_tdata = {{(RSP_BITS-1){1'b0}}, overlap};

endmodule
